[src/cdp_pkg.sv]
// Shared types and constants of the clock synthesizer divider planner.
package cdp_pkg;

	localparam logic [27:0] TARGET_MIN = 28'd1000000;
	localparam logic [27:0] TARGET_MAX = 28'd225000000;
	localparam logic [19:0] FRAC_DEN   = 20'd1000000;
	localparam logic [47:0] M_LOW      = 48'd14;
	localparam logic [47:0] M_HIGH     = 48'd91;
	localparam logic [17:0] P1_BIAS    = 18'd512;

	localparam logic [2:0] CFG_XTAL  = 3'd0;
	localparam logic [2:0] CFG_VMIN  = 3'd1;
	localparam logic [2:0] CFG_VMAX  = 3'd2;
	localparam logic [2:0] CFG_SRATE = 3'd3;
	localparam logic [2:0] CFG_QUAD  = 3'd4;
	localparam logic [2:0] CFG_SEL   = 3'd5;

	localparam logic [1:0] SEL_BEST  = 2'd0;
	localparam logic [1:0] SEL_MID   = 2'd1;
	localparam logic [1:0] SEL_WORST = 2'd2;
	localparam logic [1:0] SEL_FRAC  = 2'd3;

	typedef struct packed {
		logic [9:0]  rank;
		logic [18:0] abs_off;
		logic [9:0]  n;
		logic [6:0]  m;
		logic [27:0] lo;
	} cand_t;

endpackage

[src/cdp_ifs.sv]
// Valid/ready channel interfaces for request and result words.
interface cdp_in_if;
	logic        valid;
	logic        ready;
	logic [27:0] lo_req;
	modport source(output valid, output lo_req, input ready);
	modport sink(input valid, input lo_req, output ready);
endinterface

interface cdp_out_if;
	logic               valid;
	logic               ready;
	logic        [27:0] lo_set;
	logic signed [19:0] lo_err;
	logic        [9:0]  out_divider;
	logic        [7:0]  pll_int;
	logic        [19:0] pll_num;
	logic        [19:0] pll_den;
	logic        [17:0] word_p1;
	logic        [19:0] word_p2;
	logic        [19:0] word_p3;
	logic               is_fractional;
	logic               range_error;
	modport source(output valid, output lo_set, output lo_err, output out_divider,
		output pll_int, output pll_num, output pll_den, output word_p1, output word_p2,
		output word_p3, output is_fractional, output range_error, input ready);
	modport sink(input valid, input lo_set, input lo_err, input out_divider,
		input pll_int, input pll_num, input pll_den, input word_p1, input word_p2,
		input word_p3, input is_fractional, input range_error, output ready);
endinterface

[src/cdp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by every division.
module cdp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [29:0] divisor,
	input  logic [5:0]  len,
	output logic        busy,
	output logic [47:0] quot,
	output logic [29:0] rem
);
	logic [47:0] q_q;
	logic [29:0] r_q;
	logic [29:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [30:0] trial;
	logic        ge;
	logic [30:0] diff;

	assign trial = {r_q, q_q[47]};
	assign ge    = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= len;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// align the used dividend bits to the top
			q_q <= dividend << (6'd48 - len);
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[46:0], ge};
			r_q <= ge ? diff[29:0] : trial[29:0];
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
	assign rem  = r_q;
endmodule

[src/cdp_table.sv]
// Candidate table memory with registered read.
module cdp_table #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IW-1:0]        waddr,
	input  cdp_pkg::cand_t       wdata,
	input  logic [IW-1:0]        raddr,
	output cdp_pkg::cand_t       rdata
);
	import cdp_pkg::*;

	cand_t mem [DEPTH];
	cand_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;
endmodule

[src/clock_synth_divider_planner.sv]
// Top level: sequencer around one shared divider that plans PLL and divider settings.
// Steps: the divider bounds, then for each scanned divider the multiplier, and when it is in
// range the output frequency; a kept candidate gets a gcd reduction, a rank and an ordered
// insert into the table. Then pick and pack, or the fractional fallback. A range error goes
// straight to the output state without any division. One request word is taken at a time.
// Reset: clears control, loads configuration defaults.
module clock_synth_divider_planner #(
	parameter int MAX_MATCHES = 32,
	parameter int MAX_DIVIDER = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [29:0] cfg_data,
	cdp_in_if.sink      in_ch,
	cdp_out_if.source   out_ch
);
	import cdp_pkg::*;

	localparam int IW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
	localparam int CW = $clog2(MAX_MATCHES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_MATCHES);
	localparam logic [9:0] CAP_Q = 10'(MAX_DIVIDER);
	localparam logic [9:0] CAP_E = 10'(MAX_DIVIDER) & 10'h3FE;

	typedef enum logic [20:0] {
		S_IDLE  = 21'd1 << 0,  S_NMIN  = 21'd1 << 1,  S_NMAX = 21'd1 << 2,
		S_LOOP  = 21'd1 << 3,  S_M     = 21'd1 << 4,  S_LOMUL = 21'd1 << 5,
		S_LO    = 21'd1 << 6,  S_GCD   = 21'd1 << 7,  S_RANK = 21'd1 << 8,
		S_INS   = 21'd1 << 9,  S_CMP   = 21'd1 << 10, S_SEL  = 21'd1 << 11,
		S_SELRD = 21'd1 << 12, S_FRAC  = 21'd1 << 13, S_FA   = 21'd1 << 14,
		S_FBMUL = 21'd1 << 15, S_FB    = 21'd1 << 16, S_FR1  = 21'd1 << 17,
		S_FR2   = 21'd1 << 18, S_WORDS = 21'd1 << 19, S_OUT  = 21'd1 << 20
	} state_t;

	// configuration
	logic [25:0] xtal_q;
	logic [29:0] vmin_q, vmax_q;
	logic [19:0] srate_q;
	logic        quad_q;
	logic [1:0]  selm_q;

	state_t      state_q;
	logic        launched_q;
	logic [27:0] target_q;
	logic [29:0] tsyn_q;
	logic [10:0] nmin_q, n_q;
	logic [9:0]  nmax_q;
	logic [45:0] prod_q;
	logic [6:0]  m_q;
	logic [27:0] lo_q;
	logic [18:0] abs_q;
	logic [19:0] x_q, y_q;
	logic [9:0]  rank_q;
	logic [CW-1:0] cnt_q, i_q;
	logic        frac_q, err_q;
	logic [10:0] a_q;
	logic [19:0] b_q, c_q;
	logic [27:0] act_q;
	logic [19:0] offo_q;
	logic [9:0]  nout_q;
	logic [17:0] p1_q;
	logic [19:0] p2_q;

	logic        out_valid_q;
	logic [27:0] o_act;
	logic [19:0] o_off;
	logic [9:0]  o_n;
	logic [7:0]  o_a;
	logic [19:0] o_b, o_c, o_p2;
	logic [17:0] o_p1;
	logic        o_frac, o_err;

	logic [25:0] xt;
	logic        div_start, div_busy, div_fin;
	logic [47:0] div_dividend, div_quot;
	logic [29:0] div_divisor, div_rem;
	logic [5:0]  div_len;

	logic        tbl_we;
	logic [IW-1:0] tbl_waddr, tbl_raddr;
	cand_t       tbl_wdata, tbl_rdata, cand;
	logic        cand_first;
	logic [CW-1:0] sel_idx;
	logic [10:0] nmin_raw, nmin_fl, nmin_ev;
	logic [30:0] lo_full;
	logic [32:0] diff, absd;
	logic [9:0]  cap;
	logic [10:0] step;
	logic        div_state;

	assign xt   = (xtal_q == '0) ? 26'd1 : xtal_q;
	assign cap  = quad_q ? CAP_Q : CAP_E;
	assign step = quad_q ? 11'd1 : 11'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_q  <= 26'd24576000;
			vmin_q  <= 30'd600000000;
			vmax_q  <= 30'd900000000;
			srate_q <= 20'd48000;
			quad_q  <= 1'b1;
			selm_q  <= SEL_BEST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_XTAL:  xtal_q  <= cfg_data[25:0];
				CFG_VMIN:  vmin_q  <= cfg_data;
				CFG_VMAX:  vmax_q  <= cfg_data;
				CFG_SRATE: srate_q <= cfg_data[19:0];
				CFG_QUAD:  quad_q  <= cfg_data[0];
				CFG_SEL:   selm_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// divider operands per state
	always_comb begin
		div_dividend = '0;
		div_divisor  = 30'd1;
		div_len      = 6'd48;
		div_state    = 1'b1;
		case (state_q)
			S_NMIN: begin
				div_dividend = 48'({1'b0, vmin_q} + {1'b0, tsyn_q} - 31'd1);
				div_divisor  = tsyn_q;
				div_len      = 6'd31;
			end
			S_NMAX: begin
				div_dividend = 48'(vmax_q);
				div_divisor  = tsyn_q;
				div_len      = 6'd30;
			end
			S_M, S_FA: begin
				div_dividend = 48'(prod_q);
				div_divisor  = 30'(xt);
				div_len      = 6'd42;
			end
			S_FB: begin
				div_dividend = 48'(prod_q);
				div_divisor  = 30'(xt);
				div_len      = 6'd46;
			end
			S_LO: begin
				div_dividend = 48'(prod_q);
				div_divisor  = 30'(n_q);
				div_len      = 6'd34;
			end
			S_GCD: begin
				div_dividend = 48'(x_q);
				div_divisor  = 30'(y_q);
				div_len      = 6'd20;
				div_state    = (y_q != '0);
			end
			S_RANK: begin
				div_dividend = 48'(n_q);
				div_divisor  = 30'(x_q);
				div_len      = 6'd11;
			end
			S_FR1: begin
				div_dividend = 48'(b_q);
				div_divisor  = 30'(x_q);
				div_len      = 6'd20;
			end
			S_FR2: begin
				div_dividend = 48'(c_q);
				div_divisor  = 30'(x_q);
				div_len      = 6'd20;
			end
			S_WORDS: begin
				div_dividend = 48'({b_q, 7'd0});
				div_divisor  = 30'(c_q);
				div_len      = 6'd27;
			end
			default: div_state = 1'b0;
		endcase
	end

	assign div_start = div_state && !launched_q;
	assign div_fin   = launched_q && !div_busy;

	cdp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.len      (div_len),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign nmin_raw = div_quot[10:0];
	assign nmin_fl  = (nmin_raw < (quad_q ? 11'd4 : 11'd6)) ? (quad_q ? 11'd4 : 11'd6)
		: nmin_raw;
	assign nmin_ev  = (!quad_q && nmin_fl[0]) ? nmin_fl + 11'd1 : nmin_fl;

	assign lo_full = quad_q ? div_quot[32:2] : div_quot[30:0];
	assign diff    = {2'b0, lo_full} - {5'b0, target_q};
	assign absd    = diff[32] ? (33'd0 - diff) : diff;

	assign cand = '{rank: rank_q, abs_off: abs_q, n: n_q[9:0], m: m_q, lo: lo_q};
	assign cand_first = (cand.rank > tbl_rdata.rank)
		|| ((cand.rank == tbl_rdata.rank) && ((cand.abs_off < tbl_rdata.abs_off)
		|| ((cand.abs_off == tbl_rdata.abs_off) && (cand.n < tbl_rdata.n))));

	always_comb begin
		case (selm_q)
			SEL_MID:   sel_idx = cnt_q >> 1;
			SEL_WORST: sel_idx = cnt_q - CW'(1);
			default:   sel_idx = '0;
		endcase
	end

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = i_q[IW-1:0];
		tbl_wdata = cand;
		tbl_raddr = sel_idx[IW-1:0];
		case (state_q)
			S_INS: begin
				tbl_we    = (i_q == '0);
				tbl_raddr = IW'(i_q - CW'(1));
			end
			S_CMP: begin
				tbl_we    = 1'b1;
				tbl_wdata = cand_first ? tbl_rdata : cand;
			end
			default: ;
		endcase
	end

	cdp_table #(.DEPTH(MAX_MATCHES), .IW(IW)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			launched_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (div_start) begin
				launched_q <= 1'b1;
			end else if (div_fin) begin
				launched_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						target_q <= in_ch.lo_req;
						tsyn_q   <= quad_q ? {in_ch.lo_req, 2'b00}
							: {2'b00, in_ch.lo_req};
						err_q    <= (in_ch.lo_req < TARGET_MIN)
							|| (in_ch.lo_req > TARGET_MAX);
						state_q  <= ((in_ch.lo_req < TARGET_MIN)
							|| (in_ch.lo_req > TARGET_MAX)) ? S_OUT : S_NMIN;
					end
				end
				S_NMIN: begin
					if (div_fin) begin
						nmin_q  <= nmin_ev;
						state_q <= S_NMAX;
					end
				end
				S_NMAX: begin
					if (div_fin) begin
						nmax_q  <= (div_quot > 48'(cap)) ? cap : div_quot[9:0];
						n_q     <= nmin_q;
						cnt_q   <= '0;
						state_q <= ((selm_q != SEL_FRAC)
							&& (nmin_q <= ((div_quot > 48'(cap)) ? {1'b0, cap}
							: div_quot[10:0]))) ? S_LOOP : S_FRAC;
					end
				end
				S_LOOP: begin
					prod_q <= 46'(tsyn_q) * 46'(n_q) + 46'(xt >> 1);
					if (n_q <= {1'b0, nmax_q} && cnt_q < CNT_MAX) begin
						state_q <= S_M;
					end else begin
						state_q <= (cnt_q != '0) ? S_SEL : S_FRAC;
					end
				end
				S_M: begin
					if (div_fin) begin
						m_q <= div_quot[6:0];
						if (div_quot <= M_LOW || div_quot >= M_HIGH) begin
							n_q     <= n_q + step;
							state_q <= S_LOOP;
						end else begin
							state_q <= S_LOMUL;
						end
					end
				end
				S_LOMUL: begin
					prod_q  <= 46'(xt) * 46'(m_q);
					state_q <= S_LO;
				end
				S_LO: begin
					if (div_fin) begin
						lo_q  <= lo_full[27:0];
						abs_q <= absd[18:0];
						if (absd < {14'd0, srate_q[19:1]}) begin
							x_q     <= {13'd0, m_q};
							y_q     <= {9'd0, n_q};
							frac_q  <= 1'b0;
							state_q <= S_GCD;
						end else begin
							n_q     <= n_q + step;
							state_q <= S_LOOP;
						end
					end
				end
				S_GCD: begin
					if (y_q == '0 && !launched_q) begin
						state_q <= frac_q ? S_FR1 : S_RANK;
					end else if (div_fin) begin
						x_q <= y_q;
						y_q <= div_rem[19:0];
					end
				end
				S_RANK: begin
					if (div_fin) begin
						rank_q  <= div_quot[9:0];
						i_q     <= cnt_q;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					if (i_q == '0) begin
						cnt_q   <= cnt_q + CW'(1);
						n_q     <= n_q + step;
						state_q <= S_LOOP;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					// shift the older entry up, or drop the candidate in here
					if (cand_first) begin
						i_q     <= i_q - CW'(1);
						state_q <= S_INS;
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						n_q     <= n_q + step;
						state_q <= S_LOOP;
					end
				end
				S_SEL: begin
					state_q <= S_SELRD;
				end
				S_SELRD: begin
					act_q   <= tbl_rdata.lo;
					offo_q  <= 20'(tbl_rdata.lo - target_q);
					nout_q  <= tbl_rdata.n;
					a_q     <= {4'd0, tbl_rdata.m};
					b_q     <= '0;
					c_q     <= 20'd1;
					state_q <= S_WORDS;
				end
				S_FRAC: begin
					prod_q  <= 46'(tsyn_q) * 46'(nmin_q);
					act_q   <= target_q;
					offo_q  <= '0;
					nout_q  <= nmin_q[9:0];
					state_q <= S_FA;
				end
				S_FA: begin
					if (div_fin) begin
						a_q     <= div_quot[10:0];
						prod_q  <= 46'(div_rem[25:0]) * 46'(FRAC_DEN);
						state_q <= S_FBMUL;
					end
				end
				S_FBMUL: begin
					state_q <= S_FB;
				end
				S_FB: begin
					if (div_fin) begin
						b_q     <= div_quot[19:0];
						x_q     <= div_quot[19:0];
						y_q     <= FRAC_DEN;
						c_q     <= FRAC_DEN;
						frac_q  <= 1'b1;
						state_q <= S_GCD;
					end
				end
				S_FR1: begin
					if (div_fin) begin
						b_q     <= div_quot[19:0];
						state_q <= S_FR2;
					end
				end
				S_FR2: begin
					if (div_fin) begin
						c_q     <= (div_quot[19:0] == '0) ? 20'd1 : div_quot[19:0];
						state_q <= S_WORDS;
					end
				end
				S_WORDS: begin
					if (div_fin) begin
						p1_q    <= {a_q, 7'd0} + 18'(div_quot[6:0]) - P1_BIAS;
						p2_q    <= div_rem[19:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ch.ready)) begin
			o_act  <= err_q ? '0 : act_q;
			o_off  <= err_q ? '0 : offo_q;
			o_n    <= err_q ? '0 : nout_q;
			o_a    <= err_q ? '0 : a_q[7:0];
			o_b    <= err_q ? '0 : b_q;
			o_c    <= err_q ? '0 : c_q;
			o_p1   <= err_q ? '0 : p1_q;
			o_p2   <= err_q ? '0 : p2_q;
			o_frac <= !err_q && (b_q != '0);
			o_err  <= err_q;
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.lo_set        = o_act;
	assign out_ch.lo_err        = o_off;
	assign out_ch.out_divider   = o_n;
	assign out_ch.pll_int       = o_a;
	assign out_ch.pll_num       = o_b;
	assign out_ch.pll_den       = o_c;
	assign out_ch.word_p1       = o_p1;
	assign out_ch.word_p2       = o_p2;
	assign out_ch.word_p3       = o_c;
	assign out_ch.is_fractional = o_frac;
	assign out_ch.range_error   = o_err;
endmodule
